// ===== sv/tas_pkg.sv =====
// ----------------------------------------------------------------------------
// tas_pkg
// Shared types and constants of the tick alarm scheduler.
// ----------------------------------------------------------------------------
package tas_pkg;

   // Default alarm table depth
   localparam int TAS_NUM_ALARMS = 16;

   // Field widths
   localparam int TICK_W   = 32;
   localparam int ID_W     = 4;
   localparam int REQ_TDATA_W = 40;  // alarm_id, deadline, zero fill to bytes
   localparam int RSP_TDATA_W = 40;  // fired_id, tick_now, zero fill to bytes

   // Only ids that fit the alarm_id field can be addressed
   localparam int ID_SPAN  = 2 ** ID_W;

   localparam logic [TICK_W-1:0] START_TICK_RESET = '0;

   typedef enum logic [2:0] {
      ST_NONE   = 3'd0,
      ST_FIRED  = 3'd1,
      ST_ARMED  = 3'd2,
      ST_CANCEL = 3'd3,
      ST_PASSED = 3'd4
   } status_type;

   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_SET  = 1'b1
   } mode_type;

endpackage

// ===== sv/tick_alarm_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// tick_alarm_scheduler_core
// Wrapping tick counter with a table of one-shot alarms on absolute deadlines.
// ----------------------------------------------------------------------------
// A req transfer either advances the tick counter (mode 0) or sets or cancels
// one alarm (mode 1). A set transfer gives one rsp transfer (armed, cancelled
// or deadline already passed) from the S_SET state, which waits while the
// result register is still occupied. A tick transfer scans the alarm table
// one entry per cycle, except while a fired result waits for the result
// register, through the single read port of the deadline memory; once all
// min(NUM_ALARMS,16) entries are scanned the final result is handed over
// from S_FIN, which also waits for the result register to be taken.
// Every alarm whose deadline matches
// the new count gives one fired result, in ascending index, the last one
// flagged by rsp_tlast; with no match a single no-alarm result is given.
// The next req transfer is taken as soon as the previous item has handed its
// final result to the output register, whether or not that has been taken.
// Writing csr_wdata with csr_we loads the counter and disarms every alarm;
// write it only while the block is idle. Deadlines are held in a memory that
// is never cleared; the armed bits sit in flip-flops cleared by reset.
// ----------------------------------------------------------------------------
module tick_alarm_scheduler_core
   import tas_pkg::*;
#(
   parameter int NUM_ALARMS = TAS_NUM_ALARMS
) (
   input  logic                   clock,
   input  logic                   reset,
   // input stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [3:0] alarm_id, [35:4] deadline
   input  logic                   req_tuser,   // [0] mode
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [3:0] fired_id, [35:4] tick_now
   output logic [2:0]             rsp_tuser,   // [2:0] status
   output logic                   rsp_tlast,
   // configuration
   input  logic                   csr_we,
   input  logic [TICK_W-1:0]      csr_wdata
);

   localparam int IDX_W  = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
   localparam int SCAN_N = (NUM_ALARMS < ID_SPAN) ? NUM_ALARMS : ID_SPAN;
   localparam int CNT_W  = $clog2(SCAN_N + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SET,
      S_SCAN,
      S_FIN
   } state_type;

   state_type              state_ff;
   logic [TICK_W-1:0]      tick_ff;
   logic [NUM_ALARMS-1:0]  armed_ff;

   // held request
   logic [ID_W-1:0]        item_id_ff;
   logic [TICK_W-1:0]      item_dl_ff;

   // scan pipeline: address issue, then compare on the read data
   logic [CNT_W-1:0]       scan_idx_ff;
   logic                   chk_vld_ff;
   logic [IDX_W-1:0]       chk_idx_ff;
   logic                   pend_vld_ff;
   logic [ID_W-1:0]        pend_id_ff;

   // result register
   logic                   rsp_tvalid_ff;
   status_type             rsp_status_ff;
   logic [ID_W-1:0]        rsp_id_ff;
   logic [TICK_W-1:0]      rsp_tick_ff;
   logic                   rsp_last_ff;

   // deadline memory
   logic [TICK_W-1:0]      dl_mem [NUM_ALARMS];
   logic [TICK_W-1:0]      mem_q_ff;
   logic                   mem_we;
   logic                   mem_re;
   logic [IDX_W-1:0]       item_idx;

   logic                   req_xfer;
   logic                   out_free;
   logic                   id_ok;
   logic                   hit;
   logic                   adv;
   logic                   scan_more;
   logic                   rsp_load;
   logic [ID_W-1:0]        req_id;
   logic [TICK_W-1:0]      req_dl;

   assign req_id   = req_tdata[ID_W-1:0];
   assign req_dl   = req_tdata[ID_W+TICK_W-1:ID_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer = req_tvalid && req_tready;

   // The result register is free when empty or being drained this cycle
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   assign item_idx = IDX_W'(item_id_ff);
   assign id_ok    = (32'(item_id_ff) < 32'(NUM_ALARMS));

   // A match needs the pending fired result moved out first; stall if blocked
   assign hit       = chk_vld_ff && armed_ff[chk_idx_ff] && (mem_q_ff == tick_ff);
   assign adv       = !(hit && pend_vld_ff && !out_free);
   assign scan_more = (scan_idx_ff != CNT_W'(SCAN_N));

   // A new result enters the output register this cycle
   assign rsp_load = ((state_ff == S_SET) && out_free) ||
                     ((state_ff == S_SCAN) && adv && hit && pend_vld_ff) ||
                     ((state_ff == S_FIN) && out_free);

   assign mem_we = (state_ff == S_SET) && out_free && id_ok;
   assign mem_re = (state_ff == S_SCAN) && adv && scan_more;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         dl_mem[item_idx] <= item_dl_ff;
      end
      if (mem_re) begin
         mem_q_ff <= dl_mem[IDX_W'(scan_idx_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tick_ff       <= START_TICK_RESET;
         armed_ff      <= '0;
         scan_idx_ff   <= '0;
         chk_vld_ff    <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // load a new result, else drop the held one once taken
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (csr_we) begin
                  tick_ff  <= csr_wdata;
                  armed_ff <= '0;
               end
               if (req_xfer) begin
                  item_id_ff <= req_id;
                  item_dl_ff <= req_dl;
                  if (mode_type'(req_tuser) == MODE_SET) begin
                     state_ff <= S_SET;
                  end else begin
                     tick_ff     <= tick_ff + 1'b1;
                     scan_idx_ff <= '0;
                     chk_vld_ff  <= 1'b0;
                     pend_vld_ff <= 1'b0;
                     state_ff    <= S_SCAN;
                  end
               end
            end

            S_SET: begin
               if (out_free) begin
                  rsp_id_ff     <= item_id_ff;
                  rsp_tick_ff   <= tick_ff;
                  rsp_last_ff   <= 1'b1;
                  if (!id_ok || item_dl_ff == '0) begin
                     rsp_status_ff <= ST_CANCEL;
                  end else if (item_dl_ff > tick_ff) begin
                     rsp_status_ff <= ST_ARMED;
                  end else begin
                     rsp_status_ff <= ST_PASSED;
                  end
                  if (id_ok) begin
                     armed_ff[item_idx] <= (item_dl_ff != '0) && (item_dl_ff > tick_ff);
                  end
                  state_ff <= S_IDLE;
               end
            end

            S_SCAN: begin
               if (adv) begin
                  // issue the next read, advance the compare stage
                  chk_vld_ff <= scan_more;
                  chk_idx_ff <= IDX_W'(scan_idx_ff);
                  if (scan_more) begin
                     scan_idx_ff <= scan_idx_ff + 1'b1;
                  end
                  if (hit) begin
                     armed_ff[chk_idx_ff] <= 1'b0;
                     pend_vld_ff <= 1'b1;
                     pend_id_ff  <= ID_W'(chk_idx_ff);
                     if (pend_vld_ff) begin
                        rsp_status_ff <= ST_FIRED;
                        rsp_id_ff     <= pend_id_ff;
                        rsp_tick_ff   <= tick_ff;
                        rsp_last_ff   <= 1'b0;
                     end
                  end
               end
               if (!scan_more && !chk_vld_ff) begin
                  state_ff <= S_FIN;
               end
            end

            S_FIN: begin
               // hand over the final result of the tick
               if (out_free) begin
                  rsp_tick_ff   <= tick_ff;
                  rsp_last_ff   <= 1'b1;
                  if (pend_vld_ff) begin
                     rsp_status_ff <= ST_FIRED;
                     rsp_id_ff     <= pend_id_ff;
                  end else begin
                     rsp_status_ff <= ST_NONE;
                     rsp_id_ff     <= '0;
                  end
                  pend_vld_ff <= 1'b0;
                  state_ff    <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-TICK_W-ID_W){1'b0}}, rsp_tick_ff, rsp_id_ff};

   // An idle block has no compare in flight and no fired result held back
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!chk_vld_ff && !pend_vld_ff))
      else $error("idle with scan work outstanding");

   // Only fired results can be followed by more results of the same item
   a_notlast_fired: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_last_ff) |-> (rsp_status_ff == ST_FIRED))
      else $error("non-final result that is not a fired alarm");

   // A reported alarm has been disarmed
   a_fired_disarmed: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_status_ff == ST_FIRED) |-> !armed_ff[IDX_W'(rsp_id_ff)])
      else $error("fired alarm still armed");

   // The scan never stalls unless a fired result is waiting for the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && !adv) |-> (rsp_tvalid_ff && !rsp_tready && pend_vld_ff))
      else $error("scan stalled without a blocked result");

endmodule

// ===== tb/tick_alarm_scheduler_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_alarm_scheduler_core_tb
// Self-checking bench for the tick alarm scheduler core.
// ----------------------------------------------------------------------------
// A table of directed set and tick transfers runs first. It covers reset, the
// field extremes, the counter wrap, cancel, passed and re-armed alarms, and
// ties between fired alarms. Random traffic follows in phases with different
// start ticks and idle patterns. Every accepted request is run through a
// local alarm-table model, and each result transfer is checked field by
// field against the oldest expected result.
// ----------------------------------------------------------------------------
module tick_alarm_scheduler_core_tb
   import tas_pkg::*;
();

   localparam int N_ALARMS      = TAS_NUM_ALARMS;
   localparam int SCAN_LEN      = (N_ALARMS < ID_SPAN) ? N_ALARMS : ID_SPAN;
   localparam int SETTLE_CYCLES = 40;      // scan of 16 entries plus margin
   localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DIR_ROWS      = 25;

   // One result transfer as the model sees it
   typedef struct {
      status_type            status;
      logic [ID_W-1:0]       id;
      logic [TICK_W-1:0]     tick;
      logic                  last;
   } alarm_rsp_type;

   // One row of the directed table: a request or a start_tick write, with an
   // optional hand-typed single result
   typedef struct {
      bit                    is_cfg;
      mode_type              mode;
      logic [ID_W-1:0]       id;
      logic [TICK_W-1:0]     val;
      bit                    typed;
      status_type            st;
      logic [ID_W-1:0]       eid;
      logic [TICK_W-1:0]     etick;
   } stim_row_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [3:0] alarm_id, [35:4] deadline
   logic                   req_tuser  = 1'b0; // [0] mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [3:0] fired_id, [35:4] tick_now
   logic [2:0]             rsp_tuser;         // [2:0] status
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [TICK_W-1:0]      csr_wdata  = '0;

   // Local copy of the alarm table
   logic [TICK_W-1:0]      tick_model;
   logic                   armed_model    [N_ALARMS];
   logic [TICK_W-1:0]      deadline_model [N_ALARMS];

   // Results still owed by the block, oldest first
   alarm_rsp_type          due_rsp_q [$];

   int                     err_cnt       = 0;
   int                     req_idle_pct  = 0;
   int                     rsp_stall_pct = 0;
   int                     hold_asked    = 0;
   int                     hold_seen     = 0;
   int                     hold_left     = 0;
   int                     cycles        = 0;

   // Directed table; the tick count after reset is 0
   stim_row_type directed_tab [DIR_ROWS] = '{
      '{0, MODE_TICK, 4'd0,  32'd0,          1, ST_NONE,   4'd0,  32'd1},
      '{0, MODE_SET,  4'd0,  32'd0,          1, ST_CANCEL, 4'd0,  32'd1},
      '{0, MODE_SET,  4'd15, 32'hFFFF_FFFF,  1, ST_ARMED,  4'd15, 32'd1},
      '{0, MODE_SET,  4'd3,  32'd1,          1, ST_PASSED, 4'd3,  32'd1},
      '{0, MODE_SET,  4'd4,  32'd3,          1, ST_ARMED,  4'd4,  32'd1},
      '{0, MODE_SET,  4'd5,  32'd3,          0, ST_NONE,   4'd0,  32'd0},
      '{0, MODE_SET,  4'd6,  32'd3,          0, ST_NONE,   4'd0,  32'd0},
      '{0, MODE_SET,  4'd7,  32'd2,          0, ST_NONE,   4'd0,  32'd0},
      '{0, MODE_SET,  4'd7,  32'd3,          0, ST_NONE,   4'd0,  32'd0},
      '{0, MODE_SET,  4'd6,  32'd0,          1, ST_CANCEL, 4'd6,  32'd1},
      '{0, MODE_TICK, 4'd0,  32'd0,          1, ST_NONE,   4'd0,  32'd2},
      '{0, MODE_TICK, 4'd0,  32'd0,          0, ST_NONE,   4'd0,  32'd0},
      '{0, MODE_TICK, 4'd9,  32'hFFFF_FFFF,  1, ST_NONE,   4'd0,  32'd4},
      '{1, MODE_TICK, 4'd0,  32'hFFFF_FFFE,  0, ST_NONE,   4'd0,  32'd0},
      '{0, MODE_SET,  4'd15, 32'hFFFF_FFFF,  1, ST_ARMED,  4'd15, 32'hFFFF_FFFE},
      '{0, MODE_SET,  4'd0,  32'hFFFF_FFFE,  1, ST_PASSED, 4'd0,  32'hFFFF_FFFE},
      '{0, MODE_SET,  4'd1,  32'h1234_5678,  0, ST_NONE,   4'd0,  32'd0},
      '{0, MODE_TICK, 4'd0,  32'd0,          1, ST_FIRED,  4'd15, 32'hFFFF_FFFF},
      '{0, MODE_TICK, 4'd0,  32'd0,          1, ST_NONE,   4'd0,  32'd0},
      '{0, MODE_SET,  4'd2,  32'd1,          1, ST_ARMED,  4'd2,  32'd0},
      '{0, MODE_SET,  4'd9,  32'd1,          0, ST_NONE,   4'd0,  32'd0},
      '{0, MODE_TICK, 4'd0,  32'd0,          0, ST_NONE,   4'd0,  32'd0},
      '{0, MODE_SET,  4'd10, 32'hAAAA_AAAA,  0, ST_NONE,   4'd0,  32'd0},
      '{0, MODE_SET,  4'd11, 32'h5555_5555,  0, ST_NONE,   4'd0,  32'd0},
      '{1, MODE_TICK, 4'd0,  32'd0,          0, ST_NONE,   4'd0,  32'd0}
   };

   tick_alarm_scheduler_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run one request through the alarm table and collect the results it owes
   task automatic alarm_step(input mode_type mode, input logic [ID_W-1:0] id,
                             input logic [TICK_W-1:0] dl,
                             output alarm_rsp_type res [ID_SPAN], output int n);
      status_type st;
      n = 0;
      if (mode == MODE_SET) begin
         if (int'(id) >= N_ALARMS) begin
            st = ST_CANCEL;
         end else begin
            // a set always disarms first
            armed_model[id] = 1'b0;
            if (dl == '0) begin
               st = ST_CANCEL;
            end else if (dl > tick_model) begin
               deadline_model[id] = dl;
               armed_model[id]    = 1'b1;
               st = ST_ARMED;
            end else begin
               deadline_model[id] = dl;
               st = ST_PASSED;
            end
         end
         res[0] = '{st, id, tick_model, 1'b1};
         n = 1;
      end else begin
         tick_model = tick_model + 1'b1;
         // ties fire in ascending index
         for (int i = 0; i < SCAN_LEN; i++) begin
            if (armed_model[i] && deadline_model[i] == tick_model) begin
               armed_model[i] = 1'b0;
               res[n] = '{ST_FIRED, ID_W'(i), tick_model, 1'b0};
               n++;
            end
         end
         if (n == 0) begin
            res[0] = '{ST_NONE, '0, tick_model, 1'b1};
            n = 1;
         end else begin
            res[n-1].last = 1'b1;
         end
      end
   endtask

   // Offer one request and hold it until the block takes it; idle cycles
   // before it carry random junk on the data lines
   task automatic offer_req(input mode_type mode, input logic [ID_W-1:0] id,
                            input logic [TICK_W-1:0] dl);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {4'h0, $urandom(), 4'($urandom_range(0, 15))};
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'h0, dl, id};
      do @(posedge clock); while (!req_tready);
   endtask

   // Send a request and queue what the model predicts for it
   task automatic issue(input mode_type mode, input logic [ID_W-1:0] id,
                        input logic [TICK_W-1:0] dl);
      alarm_rsp_type res [ID_SPAN];
      int            n;
      offer_req(mode, id, dl);
      alarm_step(mode, id, dl, res, n);
      for (int k = 0; k < n; k++) due_rsp_q.push_back(res[k]);
   endtask

   // Drop valid and wait until every owed result has been taken
   task automatic drain();
      req_tvalid <= 1'b0;
      while (due_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Load the counter; only while idle, after the last scan has settled
   task automatic write_start_tick(input logic [TICK_W-1:0] value);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      tick_model = value;
      for (int i = 0; i < N_ALARMS; i++) armed_model[i] = 1'b0;
   endtask

   // Random traffic: deadlines close to the count so alarms do fire,
   // plus passed, cancelled and wide random deadlines, and bursts of alarms
   // sharing one deadline followed by the tick that fires them all
   task automatic random_traffic(input int count);
      int                sent;
      int                pick;
      bit                full;
      logic [ID_W-1:0]   id;
      logic [TICK_W-1:0] dl;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         id   = ID_W'($urandom_range(0, 15));
         if (pick < 38) begin
            // data fields are ignored on a tick; fill them with junk
            issue(MODE_TICK, id, $urandom());
            sent++;
         end else if (pick < 90) begin
            if (pick < 58)      dl = tick_model + TICK_W'($urandom_range(1, 6));
            else if (pick < 66) dl = tick_model - TICK_W'($urandom_range(0, 3));
            else if (pick < 73) dl = '0;
            else                dl = $urandom();
            issue(MODE_SET, id, dl);
            sent++;
         end else begin
            full = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < ID_SPAN; i++) begin
               if (full || $urandom_range(0, 1) == 1) begin
                  issue(MODE_SET, ID_W'(i), tick_model + 1'b1);
                  sent++;
               end
            end
            issue(MODE_TICK, id, $urandom());
            sent++;
         end
      end
   endtask

   // Receiver: random stalls, a long hold-off on request, and the checker
   always @(posedge clock) begin
      alarm_rsp_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (due_rsp_q.size() == 0) begin
            $display("%0t: unexpected result status %0d id %0d tick %h last %0d",
                     $time, rsp_tuser, rsp_tdata[3:0], rsp_tdata[35:4], rsp_tlast);
            err_cnt++;
         end else begin
            want = due_rsp_q.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[3:0] !== want.id ||
                rsp_tdata[35:4] !== want.tick || rsp_tlast !== want.last) begin
               $display("%0t: expected %0d %0d %h %0d, got %0d %0d %h %0d",
                        $time, want.status, want.id, want.tick, want.last,
                        rsp_tuser, rsp_tdata[3:0], rsp_tdata[35:4], rsp_tlast);
               err_cnt++;
            end
         end
      end
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Watchdog: end the run if it never drains
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      alarm_rsp_type res [ID_SPAN];
      int            n;
      tick_model = START_TICK_RESET;
      for (int i = 0; i < N_ALARMS; i++) begin
         armed_model[i]    = 1'b0;
         deadline_model[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: typed rows carry their single result, others use the
      // model
      for (int r = 0; r < DIR_ROWS; r++) begin
         if (directed_tab[r].is_cfg) begin
            write_start_tick(directed_tab[r].val);
         end else begin
            offer_req(directed_tab[r].mode, directed_tab[r].id, directed_tab[r].val);
            alarm_step(directed_tab[r].mode, directed_tab[r].id, directed_tab[r].val,
                       res, n);
            if (directed_tab[r].typed) begin
               due_rsp_q.push_back('{directed_tab[r].st, directed_tab[r].eid,
                                     directed_tab[r].etick, 1'b1});
            end else begin
               for (int k = 0; k < n; k++) due_rsp_q.push_back(res[k]);
            end
         end
      end

      // Free running, no idling on either side
      write_start_tick('0);
      random_traffic(90);

      // Sender idles, close to the wrap
      write_start_tick(32'hFFFF_FFF0);
      req_idle_pct  = 54;
      rsp_stall_pct = 0;
      random_traffic(90);

      // Receiver stalls, random start
      write_start_tick($urandom());
      req_idle_pct  = 0;
      rsp_stall_pct = 54;
      random_traffic(90);

      // Both sides idle lightly, start at the top of the range
      write_start_tick(32'hFFFF_FFFF);
      req_idle_pct  = 11;
      rsp_stall_pct = 11;
      random_traffic(90);

      // Back-pressure: hold the receiver off while requests keep coming, then
      // pause the sender until everything owed has arrived
      write_start_tick(32'd5);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_asked++;
      random_traffic(35);
      drain();
      random_traffic(35);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_cnt == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/tas_pkg.sv
sv/tick_alarm_scheduler_core.sv
tb/tick_alarm_scheduler_core_tb.sv
